FILE: sv/bgc_pkg.sv
// bgc_pkg: shared types, constants and helpers for the button gesture classifier
// no dependencies; used by bgc_fsm and button_gesture_classifier
package bgc_pkg;

	// width of the armed-window countdown
	localparam int unsigned TIMER_BITS = 16;

	localparam int unsigned LOCK_W = 8;
	localparam int unsigned WIN_W  = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG    = 2'd2;

	// configuration reset values
	localparam logic [LOCK_W-1:0] LOCKOUT_RST = 8'd10;
	localparam logic [WIN_W-1:0]  DOUBLE_RST  = 16'd300;
	localparam logic [WIN_W-1:0]  LONG_RST    = 16'd750;

	typedef enum logic [1:0] {
		G_NONE   = 2'd0,
		G_SINGLE = 2'd1,
		G_DOUBLE = 2'd2,
		G_LONG   = 2'd3
	} gesture_t;

	typedef struct packed {
		logic [LOCK_W-1:0] lockout_ticks;
		logic [WIN_W-1:0]  double_window_ticks;
		logic [WIN_W-1:0]  long_window_ticks;
	} cfg_t;

	// saturating load of a window register into the timer width
	function automatic logic [TIMER_BITS-1:0] timer_load(input logic [WIN_W-1:0] v);
		logic [32:0] w;
		logic [32:0] mx;
		w  = 33'(v);
		mx = (33'd1 << TIMER_BITS) - 33'd1;
		if (w > mx) begin
			return TIMER_BITS'(mx);
		end
		return TIMER_BITS'(w);
	endfunction

endpackage

FILE: sv/bgc_fsm.sv
// bgc_fsm: gesture state machine with window and lockout timers
// depends on bgc_pkg
module bgc_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              level,
	input  bgc_pkg::cfg_t     cfg,
	output bgc_pkg::gesture_t gesture_nxt
);

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_PRESSED  = 2'd1,
		PH_RELEASED = 2'd2
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic [bgc_pkg::TIMER_BITS-1:0]  window_q, window_d;
	logic [bgc_pkg::LOCK_W-1:0]      lock_q, lock_d;
	logic                            prev_q;
	logic                            accepted;
	logic                            acted;
	phase_t                          ph;

	always_comb begin
		accepted    = (level != prev_q) && (lock_q == '0);
		acted       = 1'b0;
		gesture_nxt = bgc_pkg::G_NONE;
		lock_d      = (lock_q != '0) ? lock_q - 1'b1 : lock_q;
		window_d    = window_q;
		unique case (phase_q)
			PH_PRESSED:  ph = PH_PRESSED;
			PH_RELEASED: ph = PH_RELEASED;
			default:     ph = PH_IDLE;
		endcase
		phase_d = ph;

		if (accepted) begin
			if (level) begin
				if (ph == PH_IDLE) begin
					phase_d  = PH_PRESSED;
					window_d = bgc_pkg::timer_load(cfg.long_window_ticks);
					lock_d   = cfg.lockout_ticks;
					acted    = 1'b1;
				end else if (ph == PH_RELEASED) begin
					phase_d     = PH_IDLE;
					window_d    = '0;
					gesture_nxt = bgc_pkg::G_DOUBLE;
					acted       = 1'b1;
				end
			end else if (ph == PH_PRESSED) begin
				phase_d  = PH_RELEASED;
				window_d = bgc_pkg::timer_load(cfg.double_window_ticks);
				lock_d   = cfg.lockout_ticks;
				acted    = 1'b1;
			end
		end

		// window countdown and timeout
		if (!acted && ph != PH_IDLE) begin
			if (window_q <= bgc_pkg::TIMER_BITS'(1)) begin
				gesture_nxt = (ph == PH_PRESSED) ? bgc_pkg::G_LONG : bgc_pkg::G_SINGLE;
				phase_d     = PH_IDLE;
				window_d    = '0;
			end else begin
				window_d = window_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			window_q <= '0;
			lock_q   <= '0;
			prev_q   <= 1'b0;
		end else if (en) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			lock_q   <= lock_d;
			prev_q   <= level;
		end
	end

`ifndef SYNTHESIS
	a_double_from_released: assert property (@(posedge clk) disable iff (!arst_n)
		(en && gesture_nxt == bgc_pkg::G_DOUBLE) |-> (phase_q == PH_RELEASED))
		else $error("double reported outside released phase");

	a_report_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(en && gesture_nxt != bgc_pkg::G_NONE) |=> (phase_q == PH_IDLE && window_q == '0))
		else $error("state not idle after a report");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(phase_q) && $stable(window_q) && $stable(lock_q)))
		else $error("state moved without a request");
`endif

endmodule

FILE: sv/button_gesture_classifier.sv
// button_gesture_classifier: top level with input register, config registers,
// result register and handshakes; depends on bgc_pkg and bgc_fsm
//
// latency: an accepted request is registered in the input stage, then in the result register, where its result shows
// throughput: one request per cycle when the result channel does not stall; the state update is one pass of the fsm
// reset: arst_n clears both pipeline valids and the fsm state, loads config defaults
module button_gesture_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	// input request channel
	input  logic                              button_valid,
	output logic                              button_stall,
	input  logic                              button_down,
	// result channel
	output logic                              gesture_valid,
	input  logic                              gesture_stall,
	output logic [1:0]                        gesture,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bgc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// input stage
	logic               valid_s1;
	logic               level_s1;
	// result register
	logic               gvalid_q;
	bgc_pkg::gesture_t  gesture_q;
	bgc_pkg::gesture_t  gesture_nxt;
	// configuration
	bgc_pkg::cfg_t      cfg_q;

	logic out_free;
	logic s1_free;
	logic step;

	// result register frees when empty or being taken this cycle
	assign out_free     = !gvalid_q || !gesture_stall;
	// the input stage frees when empty or moving into the result register
	assign s1_free      = !valid_s1 || out_free;
	assign step         = valid_s1 && out_free;
	assign button_stall = !s1_free;

	assign gesture_valid = gvalid_q;
	assign gesture       = gesture_q;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= button_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && button_valid) begin
			level_s1 <= button_down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gvalid_q <= 1'b0;
		end else if (out_free) begin
			gvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			gesture_q <= gesture_nxt;
		end
	end

	// register writes; index three is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ticks       <= bgc_pkg::LOCKOUT_RST;
			cfg_q.double_window_ticks <= bgc_pkg::DOUBLE_RST;
			cfg_q.long_window_ticks   <= bgc_pkg::LONG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bgc_pkg::REG_LOCKOUT: cfg_q.lockout_ticks <= cfg_data[bgc_pkg::LOCK_W-1:0];
				bgc_pkg::REG_DOUBLE:  cfg_q.double_window_ticks <= cfg_data;
				bgc_pkg::REG_LONG:    cfg_q.long_window_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// gesture decision for the item in the input stage
	bgc_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (step),
		.level       (level_s1),
		.cfg         (cfg_q),
		.gesture_nxt (gesture_nxt)
	);

`ifndef SYNTHESIS
	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> gvalid_q)
		else $error("fsm step did not produce a result");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		button_stall |-> (valid_s1 && gvalid_q && gesture_stall))
		else $error("input stalled with room in the pipeline");

	a_held_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(gvalid_q && gesture_stall) |=> ($stable(gesture_q) && !$past(step)))
		else $error("held result changed");
`endif

endmodule
